// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants, mode codes and controller/datapath interface types for the
// smoothstep fade/scale tween.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int DURATION_BITS = 16;
  localparam int SCALE_BITS    = 16;
  localparam int ALPHA_W       = 16;
  localparam int FRAC_BITS     = 16;

  localparam int ELAP_W     = DURATION_BITS + 1;
  localparam int GAIN_W     = FRAC_BITS + 1;
  localparam int MUL_A_W    = GAIN_W;
  localparam int MUL_B_W    = FRAC_BITS + 2;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int STEP_CNT_W = $clog2(FRAC_BITS);

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << FRAC_BITS;
  localparam logic [MUL_B_W-1:0] EASE_K    = MUL_B_W'(3) << FRAC_BITS;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << (ALPHA_W - 1);
  localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(256);

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_NONE      = 3'd0;
  localparam mode_t MODE_FADE_IN   = 3'd1;
  localparam mode_t MODE_SCALE_IN  = 3'd2;
  localparam mode_t MODE_FADE_OUT  = 3'd3;
  localparam mode_t MODE_SCALE_OUT = 3'd4;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul_t2;
    logic mul_ease;
    logic mul_value;
    logic update;
    logic out_load;
  } sst_cmd_t;

  typedef struct packed {
    logic kind;
    logic active;
    logic t_full;
  } sst_sts_t;

endpackage

// ===== rtl/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: request handshake, divider step count, multiply schedule and
// output register valid.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  sst_sts_t sts_i,
  output sst_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MT2   = 3'd2;
  localparam logic [2:0] ST_MEASE = 3'd3;
  localparam logic [2:0] ST_MVAL  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          if (sts_i.kind == KIND_START || !sts_i.active) begin
            state_d = ST_DONE;
          end else if (sts_i.t_full) begin
            state_d = ST_MT2;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(FRAC_BITS - 1)) begin
          state_d = ST_MT2;
        end
      end
      ST_MT2: begin
        cmd_o.mul_t2 = 1'b1;
        state_d      = ST_MEASE;
      end
      ST_MEASE: begin
        cmd_o.mul_ease = 1'b1;
        state_d        = ST_MVAL;
      end
      ST_MVAL: begin
        cmd_o.mul_value = 1'b1;
        state_d         = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/sst_datapath.sv =====
// ----------------------------------------------------------------------------
// sst_datapath
// Tween state, restoring divider for t, shared registered multiplier for the
// smoothstep and gain products, and the output register.
// ----------------------------------------------------------------------------
module sst_datapath import sst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  kind_i,
  input  logic [2:0]            effect_i,
  input  logic [15:0]           duration_i,
  input  logic [15:0]           start_alpha_i,
  input  logic [15:0]           start_scale_i,
  input  sst_cmd_t              cmd_i,
  output sst_sts_t              sts_o,
  output logic [15:0]           alpha_out_o,
  output logic [15:0]           scale_out_o,
  output logic                  effect_active_o,
  output logic                  delete_pulse_o
);

  mode_t                     mode_q;
  logic [ELAP_W-1:0]         elapsed_q;
  logic [DURATION_BITS-1:0]  length_q;
  logic [ALPHA_W-1:0]        tgt_alpha_q, cur_alpha_q;
  logic [SCALE_BITS-1:0]     tgt_scale_q, cur_scale_q;
  logic                      del_q;

  logic [DURATION_BITS-1:0]  rem_q;
  logic [GAIN_W-1:0]         t_q;
  logic [PROD_W-1:0]         prod_q;

  logic [15:0]               alpha_oq, scale_oq;
  logic                      active_oq, del_oq;

  mode_t                     eff_sel;
  logic [DURATION_BITS-1:0]  dur, len_sel;
  logic [ALPHA_W-1:0]        a_sat;
  logic [SCALE_BITS-1:0]     s_in;
  logic                      t_full, is_fade, is_in;
  logic [DURATION_BITS:0]    rem_shift, rem_sub;
  logic                      rem_ge;
  logic [GAIN_W-1:0]         ease, gain;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic [15:0]               value;
  logic [ELAP_W-1:0]         elapsed_n;

  assign t_full  = elapsed_q >= ELAP_W'(length_q);
  assign is_fade = (mode_q == MODE_FADE_IN) || (mode_q == MODE_FADE_OUT);
  assign is_in   = (mode_q == MODE_FADE_IN) || (mode_q == MODE_SCALE_IN);

  assign sts_o.kind   = kind_i;
  assign sts_o.active = mode_q != MODE_NONE;
  assign sts_o.t_full = t_full;

  assign eff_sel = (effect_i > MODE_SCALE_OUT) ? MODE_NONE : effect_i;
  assign dur     = duration_i[DURATION_BITS-1:0];
  assign len_sel = (dur == '0) ? DURATION_BITS'(1) : dur;
  assign a_sat   = (start_alpha_i > ALPHA_ONE) ? ALPHA_ONE : start_alpha_i;
  assign s_in    = start_scale_i[SCALE_BITS-1:0];

  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, length_q};
  assign rem_sub   = rem_shift - {1'b0, length_q};

  assign ease = prod_q[FRAC_BITS +: GAIN_W];
  assign gain = is_in ? ease : (GAIN_ONE - ease);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_t2) begin
      mul_a = t_q;
      mul_b = MUL_B_W'(t_q);
    end else if (cmd_i.mul_ease) begin
      mul_a = prod_q[FRAC_BITS +: GAIN_W];
      mul_b = EASE_K - MUL_B_W'({t_q, 1'b0});
    end else if (cmd_i.mul_value) begin
      mul_a = gain;
      mul_b = is_fade ? MUL_B_W'(tgt_alpha_q) : MUL_B_W'(tgt_scale_q);
    end
  end

  assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign value     = prod_q[FRAC_BITS +: 16];
  assign elapsed_n = elapsed_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      elapsed_q   <= '0;
      length_q    <= DURATION_BITS'(1);
      tgt_alpha_q <= ALPHA_ONE;
      tgt_scale_q <= SCALE_ONE;
      cur_alpha_q <= ALPHA_ONE;
      cur_scale_q <= SCALE_ONE;
      del_q       <= 1'b0;
    end else if (cmd_i.accept) begin
      del_q <= 1'b0;
      if (kind_i == KIND_START) begin
        mode_q      <= eff_sel;
        elapsed_q   <= '0;
        length_q    <= len_sel;
        tgt_alpha_q <= a_sat;
        tgt_scale_q <= s_in;
        cur_alpha_q <= (eff_sel == MODE_FADE_IN) ? '0 : a_sat;
        cur_scale_q <= (eff_sel == MODE_SCALE_IN) ? '0 : s_in;
      end
    end else if (cmd_i.update) begin
      elapsed_q <= elapsed_n;
      if (elapsed_n > ELAP_W'(length_q)) begin
        mode_q <= MODE_NONE;
        del_q  <= !is_in;
        unique case (mode_q)
          MODE_FADE_IN:  cur_alpha_q <= tgt_alpha_q;
          MODE_SCALE_IN: cur_scale_q <= tgt_scale_q;
          MODE_FADE_OUT: cur_alpha_q <= '0;
          default:       cur_scale_q <= '0;
        endcase
      end else if (is_fade) begin
        cur_alpha_q <= value[ALPHA_W-1:0];
      end else begin
        cur_scale_q <= value[SCALE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rem_q <= elapsed_q[DURATION_BITS-1:0];
      t_q   <= t_full ? GAIN_ONE : '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[DURATION_BITS-1:0] : rem_shift[DURATION_BITS-1:0];
      t_q   <= {t_q[GAIN_W-2:0], rem_ge};
    end
    if (cmd_i.mul_t2 || cmd_i.mul_ease || cmd_i.mul_value) begin
      prod_q <= mul_p;
    end
    if (cmd_i.out_load) begin
      alpha_oq  <= 16'(cur_alpha_q);
      scale_oq  <= 16'(cur_scale_q);
      active_oq <= mode_q != MODE_NONE;
      del_oq    <= del_q;
    end
  end

  assign alpha_out_o     = alpha_oq;
  assign scale_out_o     = scale_oq;
  assign effect_active_o = active_oq;
  assign delete_pulse_o  = del_oq;

endmodule

// ===== rtl/smoothstep_fade_scale_tween.sv =====
// ----------------------------------------------------------------------------
// smoothstep_fade_scale_tween
// Smoothstep-eased fade and scale tween for one sprite's alpha and scale.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one request: a start
// (kind 0: effect, duration, start alpha/scale) or a frame tick (kind 1).
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// request: current alpha (Q1.15), scale (Q8.8), active flag, delete pulse.
// One request is in flight at a time; in_stall_o is high while it is worked.
// A start or an idle tick goes straight to the output load. A tick with t
// clamped to one makes three passes through one shared registered
// multiplier, then the state update and the output load; any other tick
// first runs the restoring divider for t (one quotient bit a cycle).
// A new request is taken only once the last result is loaded into the
// output register.
// A finished result sits in the output register; while out_stall_i holds it,
// the next request can be accepted and worked, and its result waits until
// the register frees up. Reset clears the output valid, drops any effect and
// restores full alpha, unit scale and a length of one.
// ----------------------------------------------------------------------------
module smoothstep_fade_scale_tween import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [2:0]  effect_i,
  input  logic [15:0] duration_i,
  input  logic [15:0] start_alpha_i,
  input  logic [15:0] start_scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] alpha_out_o,
  output logic [15:0] scale_out_o,
  output logic        effect_active_o,
  output logic        delete_pulse_o
);

  sst_cmd_t cmd;
  sst_sts_t sts;

  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sst_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (kind_i),
    .effect_i        (effect_i),
    .duration_i      (duration_i),
    .start_alpha_i   (start_alpha_i),
    .start_scale_i   (start_scale_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .alpha_out_o     (alpha_out_o),
    .scale_out_o     (scale_out_o),
    .effect_active_o (effect_active_o),
    .delete_pulse_o  (delete_pulse_o)
  );

endmodule

// ===== rtl/sst_checker.sv =====
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks for the tween, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker import sst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] alpha_out_o,
  input logic [15:0] scale_out_o,
  input logic        effect_active_o,
  input logic        delete_pulse_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(alpha_out_o) &&
      $stable(scale_out_o) && $stable(effect_active_o) && $stable(delete_pulse_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous still in work");

  a_delete_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delete_pulse_o |->
      !effect_active_o && (alpha_out_o == '0 || scale_out_o == '0))
    else $error("delete pulse without a finished out effect");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alpha_out_o <= ALPHA_ONE)
    else $error("alpha above one");

endmodule

bind smoothstep_fade_scale_tween sst_checker u_sst_checker (.*);
